// ===== src/fdm_pkg.sv =====
// Shared types and constants for the motor drive fault monitor.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fdm_pkg;

    // Field widths.
    localparam int CurrentWidth   = 16;
    localparam int MagWidth       = CurrentWidth + 1;
    localparam int OcLimitWidth   = 15;
    localparam int VoltWidth      = 16;
    localparam int TempWidth      = 16;
    localparam int OtLimitWidth   = 15;
    localparam int CfgIndexWidth  = 3;
    localparam int CfgDataWidth   = 16;
    localparam int NumPhases      = 3;

    // Configuration register indexes.
    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_OVER_CURRENT_LIMIT     = 3'd0,
        CFG_OVER_VOLTAGE_LIMIT     = 3'd1,
        CFG_UNDER_VOLTAGE_LIMIT    = 3'd2,
        CFG_OVER_TEMPERATURE_LIMIT = 3'd3,
        CFG_ARMED                  = 3'd4
    } cfg_index_t;

    // Item operations.
    typedef enum logic {
        OP_EVALUATE = 1'b0,
        OP_DELIVER  = 1'b1
    } op_t;

    // Fault reasons.
    typedef enum logic [1:0] {
        REASON_OVER_CURRENT     = 2'd0,
        REASON_OVER_VOLTAGE     = 2'd1,
        REASON_UNDER_VOLTAGE    = 2'd2,
        REASON_OVER_TEMPERATURE = 2'd3
    } reason_t;

    // Trip findings of the check lanes for one item.
    typedef struct packed {
        logic over_current;
        logic over_voltage;
        logic under_voltage;
        logic over_temperature;
    } trip_t;

    // Result of one item.
    typedef struct packed {
        logic    fault_asserted;
        logic    notify_valid;
        reason_t notify_reason;
        logic    notify_pending;
    } result_t;

endpackage

`default_nettype wire

// ===== src/motor_drive_fault_monitor_top.sv =====
// Motor drive fault monitor, top level: configuration, check lanes, output stage.
// Two register stages: the lane findings register, then the output register.
// Throughput: one item per cycle; ready is held low only by a stalled result.
// Reset (aresetn, synchronous, active low) zeroes all limits, disarms the
// monitor and clears the fault flags; no clearing pass is needed.
// Depends on fdm_pkg, fdm_current_lane and fdm_fault_merge.
`default_nettype none

module motor_drive_fault_monitor_top
    import fdm_pkg::*;
(
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port.
    input  wire logic                           cfg_wr_en,
    input  wire logic [CfgIndexWidth-1:0]       cfg_index,
    input  wire logic [CfgDataWidth-1:0]        cfg_wdata,
    // Input channel.
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_operation,
    input  wire logic signed [CurrentWidth-1:0] s_current_a,
    input  wire logic signed [CurrentWidth-1:0] s_current_b,
    input  wire logic signed [CurrentWidth-1:0] s_current_c,
    input  wire logic [VoltWidth-1:0]           s_bus_voltage,
    input  wire logic signed [TempWidth-1:0]    s_winding_temperature,
    // Result channel.
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_fault_asserted,
    output logic                                m_notify_valid,
    output logic [1:0]                          m_notify_reason,
    output logic                                m_notify_pending
);

    logic [OcLimitWidth-1:0] oc_limit_reg;
    logic [VoltWidth-1:0]    ov_limit_reg;
    logic [VoltWidth-1:0]    uv_limit_reg;
    logic [OtLimitWidth-1:0] ot_limit_reg;
    logic                    armed_reg;
    logic                    cfg_clear;

    logic signed [CurrentWidth-1:0] phase_current [NumPhases];
    logic [NumPhases-1:0]           phase_hit;
    trip_t                          trip_now;

    logic    s1_valid_reg;
    op_t     s1_op_reg;
    trip_t   s1_trip_reg;
    logic    s1_advance;
    logic    out_free;
    logic    s_accept;
    result_t merge_result;

    logic    m_valid_reg;
    result_t m_result_reg;

    // Configuration registers; limit writes and disarming clear the flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oc_limit_reg <= '0;
            ov_limit_reg <= '0;
            uv_limit_reg <= '0;
            ot_limit_reg <= '0;
            armed_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_OVER_CURRENT_LIMIT:     oc_limit_reg <= cfg_wdata[OcLimitWidth-1:0];
                CFG_OVER_VOLTAGE_LIMIT:     ov_limit_reg <= cfg_wdata[VoltWidth-1:0];
                CFG_UNDER_VOLTAGE_LIMIT:    uv_limit_reg <= cfg_wdata[VoltWidth-1:0];
                CFG_OVER_TEMPERATURE_LIMIT: ot_limit_reg <= cfg_wdata[OtLimitWidth-1:0];
                CFG_ARMED:                  armed_reg    <= cfg_wdata[0];
                default:                    armed_reg    <= armed_reg;
            endcase
        end
    end

    always_comb begin
        cfg_clear = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_OVER_CURRENT_LIMIT,
                CFG_OVER_VOLTAGE_LIMIT,
                CFG_UNDER_VOLTAGE_LIMIT,
                CFG_OVER_TEMPERATURE_LIMIT: cfg_clear = 1'b1;
                CFG_ARMED:                  cfg_clear = !cfg_wdata[0];
                default:                    cfg_clear = 1'b0;
            endcase
        end
    end

    // Phase current lanes, one per phase.
    assign phase_current[0] = s_current_a;
    assign phase_current[1] = s_current_b;
    assign phase_current[2] = s_current_c;

    for (genvar i = 0; i < NumPhases; i++) begin : g_phase
        fdm_current_lane u_lane (
            .current    (phase_current[i]),
            .limit      (oc_limit_reg),
            .over_limit (phase_hit[i])
        );
    end

    // Over-current, bus voltage and temperature checks; a zero limit disables its check.
    always_comb begin
        trip_now.over_current     = (oc_limit_reg != '0) && (|phase_hit);
        trip_now.over_voltage     = (ov_limit_reg != '0) && (s_bus_voltage > ov_limit_reg);
        trip_now.under_voltage    = (uv_limit_reg != '0) && (s_bus_voltage < uv_limit_reg);
        trip_now.over_temperature = (ot_limit_reg != '0)
            && (s_winding_temperature > $signed({1'b0, ot_limit_reg}));
    end

    // Pipeline handshake: both stages move whenever the output can take a result.
    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_ready    = !s1_valid_reg || out_free;
    assign s_accept   = s_valid && s_ready;

    // Lane findings register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg   <= op_t'(s_operation);
            s1_trip_reg <= trip_now;
        end
    end

    // Merge stage with the fault flags.
    fdm_fault_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_en   (s1_advance),
        .op        (s1_op_reg),
        .trip      (s1_trip_reg),
        .armed     (armed_reg),
        .cfg_clear (cfg_clear),
        .result    (merge_result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_result_reg <= merge_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_fault_asserted = m_result_reg.fault_asserted;
    assign m_notify_valid   = m_result_reg.notify_valid;
    assign m_notify_reason  = m_result_reg.notify_reason;
    assign m_notify_pending = m_result_reg.notify_pending;

endmodule

`default_nettype wire

// ===== src/fdm_current_lane.sv =====
// One phase current lane: 17-bit magnitude and compare against the trip limit.
// Depends on fdm_pkg.
`default_nettype none

module fdm_current_lane
    import fdm_pkg::*;
(
    input  wire logic signed [CurrentWidth-1:0] current,
    input  wire logic        [OcLimitWidth-1:0] limit,
    output logic                                over_limit
);

    logic [MagWidth-1:0] magnitude;

    // Magnitude of a two's complement value, one bit wider so -32768 fits.
    always_comb begin
        if (current[CurrentWidth-1]) begin
            magnitude = MagWidth'(0) - {current[CurrentWidth-1], current};
        end else begin
            magnitude = {1'b0, current};
        end
    end

    assign over_limit = magnitude > MagWidth'(limit);

endmodule

`default_nettype wire

// ===== src/fdm_fault_merge.sv =====
// Merge stage: priority selection of the lane trips and the fault flags.
// Holds asserted, notified and pending state; depends on fdm_pkg.
`default_nettype none

module fdm_fault_merge
    import fdm_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    item_en,
    input  wire op_t     op,
    input  wire trip_t   trip,
    input  wire logic    armed,
    input  wire logic    cfg_clear,
    output result_t      result
);

    logic    asserted_reg, asserted_next;
    logic    notified_reg, notified_next;
    logic    pending_reg, pending_next;
    reason_t reason_reg, reason_next;
    reason_t trip_reason;
    logic    tripped;
    logic    notify_valid;
    reason_t notify_reason;

    // Highest-priority reason among the lanes that tripped.
    always_comb begin
        tripped = trip.over_current | trip.over_voltage
                | trip.under_voltage | trip.over_temperature;
        priority if (trip.over_current) begin
            trip_reason = REASON_OVER_CURRENT;
        end else if (trip.over_voltage) begin
            trip_reason = REASON_OVER_VOLTAGE;
        end else if (trip.under_voltage) begin
            trip_reason = REASON_UNDER_VOLTAGE;
        end else begin
            trip_reason = REASON_OVER_TEMPERATURE;
        end
    end

    // Flag update for one item.
    always_comb begin
        asserted_next = asserted_reg;
        notified_next = notified_reg;
        pending_next  = pending_reg;
        reason_next   = reason_reg;
        notify_valid  = 1'b0;
        notify_reason = REASON_OVER_CURRENT;
        if (item_en) begin
            unique case (op)
                OP_EVALUATE: begin
                    if (armed) begin
                        asserted_next = tripped;
                        if (!tripped) begin
                            notified_next = 1'b0;
                        end else if (!notified_reg) begin
                            reason_next  = trip_reason;
                            pending_next = 1'b1;
                        end
                    end
                end
                OP_DELIVER: begin
                    if (pending_reg) begin
                        pending_next  = 1'b0;
                        notified_next = 1'b1;
                        notify_valid  = 1'b1;
                        notify_reason = reason_reg;
                    end
                end
                default: begin
                    asserted_next = asserted_reg;
                end
            endcase
        end
    end

    assign result.fault_asserted = asserted_next;
    assign result.notify_valid   = notify_valid;
    assign result.notify_reason  = notify_reason;
    assign result.notify_pending = pending_next;

    // State registers; a configuration clear ends any fault episode.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asserted_reg <= 1'b0;
            notified_reg <= 1'b0;
            pending_reg  <= 1'b0;
            reason_reg   <= REASON_OVER_CURRENT;
        end else if (cfg_clear) begin
            asserted_reg <= 1'b0;
            notified_reg <= 1'b0;
            pending_reg  <= 1'b0;
        end else begin
            asserted_reg <= asserted_next;
            notified_reg <= notified_next;
            pending_reg  <= pending_next;
            reason_reg   <= reason_next;
        end
    end

`ifndef SYNTHESIS
    // A notification is only handed out when one was pending.
    a_notify_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        item_en && result.notify_valid |-> pending_reg)
        else $error("notification delivered with nothing pending");

    // A delivered notification leaves the episode marked notified.
    a_deliver_marks_notified: assert property (@(posedge aclk) disable iff (!aresetn)
        item_en && result.notify_valid && !cfg_clear |=> notified_reg && !pending_reg)
        else $error("delivery did not mark the fault notified");

    // A configuration clear drops all flags.
    a_cfg_clear_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_clear |=> !asserted_reg && !notified_reg && !pending_reg)
        else $error("configuration write did not clear the flags");

    // An episode already notified never has a reason pending.
    a_notified_not_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !(notified_reg && pending_reg))
        else $error("fault both notified and pending");
`endif

endmodule

`default_nettype wire

// ===== bench/fault_monitor_checker.sv =====
// Checker for the motor drive fault monitor: watches the configuration port and both
// item channels, predicts every result and compares it field by field.
// Depends on fdm_pkg.
module fault_monitor_checker
    import fdm_pkg::*;
(
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [CfgIndexWidth-1:0]       cfg_index,
    input  wire logic [CfgDataWidth-1:0]        cfg_wdata,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic                           s_operation,
    input  wire logic signed [CurrentWidth-1:0] s_current_a,
    input  wire logic signed [CurrentWidth-1:0] s_current_b,
    input  wire logic signed [CurrentWidth-1:0] s_current_c,
    input  wire logic [VoltWidth-1:0]           s_bus_voltage,
    input  wire logic signed [TempWidth-1:0]    s_winding_temperature,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic                           m_fault_asserted,
    input  wire logic                           m_notify_valid,
    input  wire logic [1:0]                     m_notify_reason,
    input  wire logic                           m_notify_pending,
    output int                                  mismatch_count,
    output int                                  results_awaited
);

    localparam int PrintLimit = 40;

    // Predictor copy of the configuration registers.
    logic [OcLimitWidth-1:0] oc_limit;
    logic [VoltWidth-1:0]    ov_limit;
    logic [VoltWidth-1:0]    uv_limit;
    logic [OtLimitWidth-1:0] ot_limit;
    logic                    armed_q;

    // Predictor copy of the fault episode state.
    logic    asserted_q;
    logic    notified_q;
    logic    pending_q;
    reason_t pending_reason_q;

    result_t expected_status[$];
    int      result_index;

    task automatic report_mismatch(string what);
        if (mismatch_count < PrintLimit) begin
            $display("ERROR: %s", what);
        end
        mismatch_count++;
    endtask

    function automatic void clear_episode();
        asserted_q = 1'b0;
        notified_q = 1'b0;
        pending_q  = 1'b0;
    endfunction

    // Register writes take the low bits of the data; unknown indexes are ignored.
    function automatic void apply_register_write(logic [CfgIndexWidth-1:0] index,
                                                 logic [CfgDataWidth-1:0] data);
        case (index)
            CFG_OVER_CURRENT_LIMIT: begin
                oc_limit = data[OcLimitWidth-1:0];
                clear_episode();
            end
            CFG_OVER_VOLTAGE_LIMIT: begin
                ov_limit = data[VoltWidth-1:0];
                clear_episode();
            end
            CFG_UNDER_VOLTAGE_LIMIT: begin
                uv_limit = data[VoltWidth-1:0];
                clear_episode();
            end
            CFG_OVER_TEMPERATURE_LIMIT: begin
                ot_limit = data[OtLimitWidth-1:0];
                clear_episode();
            end
            CFG_ARMED: begin
                armed_q = data[0];
                if (!data[0]) begin
                    clear_episode();
                end
            end
            default: ;
        endcase
    endfunction

    // Magnitude of a phase current, one bit wider so the most negative value fits.
    function automatic logic [MagWidth-1:0] magnitude(logic signed [CurrentWidth-1:0] value);
        logic signed [MagWidth-1:0] wide;
        wide = MagWidth'(value);
        return (wide < 0) ? -wide : wide;
    endfunction

    // Advances the episode state by one item and returns the status it reports.
    function automatic result_t predict_fault_status(
        op_t                            op,
        logic signed [CurrentWidth-1:0] ia,
        logic signed [CurrentWidth-1:0] ib,
        logic signed [CurrentWidth-1:0] ic,
        logic [VoltWidth-1:0]           bus,
        logic signed [TempWidth-1:0]    temp
    );
        result_t             status;
        logic                tripped;
        reason_t             why;
        logic [MagWidth-1:0] peak;
        status = '0;
        if (op == OP_EVALUATE) begin
            if (armed_q) begin
                peak = magnitude(ia);
                if (magnitude(ib) > peak) begin
                    peak = magnitude(ib);
                end
                if (magnitude(ic) > peak) begin
                    peak = magnitude(ic);
                end
                // Checks in priority order; a zero limit switches its check off.
                tripped = 1'b1;
                why = REASON_OVER_CURRENT;
                if (oc_limit != '0 && peak > oc_limit) begin
                    why = REASON_OVER_CURRENT;
                end else if (ov_limit != '0 && bus > ov_limit) begin
                    why = REASON_OVER_VOLTAGE;
                end else if (uv_limit != '0 && bus < uv_limit) begin
                    why = REASON_UNDER_VOLTAGE;
                end else if (ot_limit != '0 && int'(temp) > int'(ot_limit)) begin
                    why = REASON_OVER_TEMPERATURE;
                end else begin
                    tripped = 1'b0;
                end
                asserted_q = tripped;
                if (!tripped) begin
                    notified_q = 1'b0;
                end else if (!notified_q) begin
                    pending_reason_q = why;
                    pending_q = 1'b1;
                end
            end
        end else if (pending_q) begin
            pending_q = 1'b0;
            notified_q = 1'b1;
            status.notify_valid = 1'b1;
            status.notify_reason = pending_reason_q;
        end
        status.fault_asserted = asserted_q;
        status.notify_pending = pending_q;
        return status;
    endfunction

    // Results are compared before this edge's item is predicted, so a result can
    // never be matched against an item accepted at the same edge.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            oc_limit = '0;
            ov_limit = '0;
            uv_limit = '0;
            ot_limit = '0;
            armed_q = 1'b0;
            clear_episode();
            pending_reason_q = REASON_OVER_CURRENT;
            expected_status.delete();
            mismatch_count = 0;
            result_index = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no item waiting",
                                              result_index));
                end else begin
                    want = expected_status.pop_front();
                    if (m_fault_asserted !== want.fault_asserted) begin
                        report_mismatch($sformatf("result %0d: fault_asserted %b, expected %b",
                            result_index, m_fault_asserted, want.fault_asserted));
                    end
                    if (m_notify_valid !== want.notify_valid) begin
                        report_mismatch($sformatf("result %0d: notify_valid %b, expected %b",
                            result_index, m_notify_valid, want.notify_valid));
                    end
                    if (m_notify_reason !== want.notify_reason) begin
                        report_mismatch($sformatf("result %0d: notify_reason %0d, expected %0d",
                            result_index, m_notify_reason, want.notify_reason));
                    end
                    if (m_notify_pending !== want.notify_pending) begin
                        report_mismatch($sformatf("result %0d: notify_pending %b, expected %b",
                            result_index, m_notify_pending, want.notify_pending));
                    end
                end
                result_index++;
            end
            if (cfg_wr_en) begin
                apply_register_write(cfg_index, cfg_wdata);
            end
            if (s_valid && s_ready) begin
                expected_status.push_back(predict_fault_status(op_t'(s_operation),
                    s_current_a, s_current_b, s_current_c, s_bus_voltage,
                    s_winding_temperature));
            end
        end
        results_awaited = expected_status.size();
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the motor drive fault monitor: clock, reset, configuration writes,
// directed and random items with random gaps and result stalls, and the verdict.
// Depends on fdm_pkg, motor_drive_fault_monitor_top and fault_monitor_checker.
module tb;
    import fdm_pkg::*;

    localparam int RandomItems = 600;
    localparam int CycleLimit  = 400000;
    localparam int LongHold    = 200;
    localparam logic [CfgIndexWidth-1:0] CfgUnusedIndex = 3'd7;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [CfgIndexWidth-1:0]       cfg_index;
    logic [CfgDataWidth-1:0]        cfg_wdata;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_operation;
    logic signed [CurrentWidth-1:0] s_current_a;
    logic signed [CurrentWidth-1:0] s_current_b;
    logic signed [CurrentWidth-1:0] s_current_c;
    logic [VoltWidth-1:0]           s_bus_voltage;
    logic signed [TempWidth-1:0]    s_winding_temperature;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_fault_asserted;
    logic                           m_notify_valid;
    logic [1:0]                     m_notify_reason;
    logic                           m_notify_pending;
    int                             mismatch_count;
    int                             results_awaited;

    // Limits as last written, used only to aim stimulus near the trip points.
    int current_trip   = 0;
    int high_volt_trip = 0;
    int low_volt_trip  = 0;
    int temp_trip      = 0;

    bit burst_mode    = 1'b0;
    bit hold_request  = 1'b0;
    bit hold_served   = 1'b0;
    int cycle_count   = 0;

    motor_drive_fault_monitor_top uut (.*);

    fault_monitor_checker checker_inst (.*);

    always #6 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        int draw;
        if (burst_mode) begin
            return 0;
        end
        draw = $urandom_range(0, 99);
        if (draw < 60) begin
            return 0;
        end
        if (draw < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Mode 0 stays at or below the limit, mode 1 sits right around it, else anything.
    function automatic logic [15:0] pick_current(int mode);
        int mag;
        case (mode)
            0: mag = (current_trip == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(0, current_trip);
            1: mag = current_trip + int'($urandom_range(0, 4)) - 2;
            default: return 16'($urandom);
        endcase
        if (mag < 0) begin
            mag = 0;
        end
        if (mag > 32768) begin
            mag = 32768;
        end
        if ($urandom_range(0, 1) == 1) begin
            return 16'(-mag);
        end
        return 16'((mag > 32767) ? 32767 : mag);
    endfunction

    function automatic logic [15:0] pick_voltage(int mode);
        int lo;
        int hi;
        int volts;
        lo = low_volt_trip;
        hi = (high_volt_trip == 0) ? 65535 : high_volt_trip;
        case (mode)
            0: volts = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(0, 65535);
            1: volts = (($urandom_range(0, 1) == 1) ? high_volt_trip : low_volt_trip)
                       + int'($urandom_range(0, 4)) - 2;
            default: volts = $urandom_range(0, 65535);
        endcase
        if (volts < 0) begin
            volts = 0;
        end
        if (volts > 65535) begin
            volts = 65535;
        end
        return 16'(volts);
    endfunction

    function automatic logic [15:0] pick_temperature(int mode);
        int degrees;
        case (mode)
            0: degrees = int'($urandom_range(0, temp_trip + 32768)) - 32768;
            1: degrees = temp_trip + int'($urandom_range(0, 4)) - 2;
            default: return 16'($urandom);
        endcase
        if (degrees > 32767) begin
            degrees = 32767;
        end
        return 16'(degrees);
    endfunction

    // Zero, all ones, any value, or a moderate value in the given range.
    function automatic logic [15:0] pick_setting(int lo, int hi);
        int draw;
        draw = $urandom_range(0, 9);
        if (draw == 0) begin
            return 16'h0000;
        end
        if (draw == 1) begin
            return 16'hFFFF;
        end
        if (draw == 2) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(hi, lo));
    endfunction

    // Offers one item after a random gap and returns after the first edge at which ready reads high.
    task automatic send_item(op_t op, logic [15:0] ia, logic [15:0] ib, logic [15:0] ic,
                             logic [15:0] bus, logic [15:0] temp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_current_a <= ia;
        s_current_b <= ib;
        s_current_c <= ic;
        s_bus_voltage <= bus;
        s_winding_temperature <= temp;
        do @(posedge aclk); while (!s_ready);
    endtask

    // A deliver item carries measurements that the block must ignore.
    task automatic deliver_notice();
        send_item(OP_DELIVER, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (results_awaited != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_register(logic [CfgIndexWidth-1:0] index,
                                logic [CfgDataWidth-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        case (index)
            CFG_OVER_CURRENT_LIMIT:     current_trip = int'(data[OcLimitWidth-1:0]);
            CFG_OVER_VOLTAGE_LIMIT:     high_volt_trip = int'(data);
            CFG_UNDER_VOLTAGE_LIMIT:    low_volt_trip = int'(data);
            CFG_OVER_TEMPERATURE_LIMIT: temp_trip = int'(data[OtLimitWidth-1:0]);
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off while items keep coming.
    initial begin
        int stall;
        int draw;
        stall = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_served) begin
                m_ready <= 1'b0;
                repeat (LongHold) @(posedge aclk);
                hold_served = 1'b1;
                m_ready <= 1'b1;
            end else if (burst_mode) begin
                m_ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                draw = $urandom_range(0, 99);
                if (draw < 75) begin
                    m_ready <= 1'b1;
                end else begin
                    stall = (draw < 95) ? $urandom_range(0, 2) : $urandom_range(15, 40);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int   issued;
        int   phase;
        int   phase_items;
        int   cur_mode;
        int   volt_mode;
        int   temp_mode;
        op_t  op;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_operation <= OP_EVALUATE;
        s_current_a <= '0;
        s_current_b <= '0;
        s_current_c <= '0;
        s_bus_voltage <= '0;
        s_winding_temperature <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Disarmed after reset: an evaluation changes nothing and nothing is pending.
        send_item(OP_EVALUATE, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h7FFF);
        deliver_notice();

        drain_results();
        set_register(CFG_OVER_CURRENT_LIMIT, 16'd1000);
        set_register(CFG_OVER_VOLTAGE_LIMIT, 16'hF000);
        set_register(CFG_UNDER_VOLTAGE_LIMIT, 16'h1000);
        set_register(CFG_OVER_TEMPERATURE_LIMIT, 16'h1000);
        set_register(CFG_ARMED, 16'h0001);

        // Over-current latched, then overwritten by over-voltage before delivery.
        send_item(OP_EVALUATE, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
        send_item(OP_EVALUATE, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        deliver_notice();
        // Tripping again after notification latches no new reason.
        send_item(OP_EVALUATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        deliver_notice();
        // Values equal to the current, under-voltage and temperature limits do not trip, which ends the episode.
        send_item(OP_EVALUATE, 16'd1000, 16'hFC18, 16'd1000, 16'h1000, 16'h1000);
        // Over-temperature, then a clean evaluation that leaves the reason pending.
        send_item(OP_EVALUATE, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
        send_item(OP_EVALUATE, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
        deliver_notice();
        // Over-current wins over over-voltage and over-temperature.
        send_item(OP_EVALUATE, 16'h0000, 16'hFC17, 16'h0000, 16'hF001, 16'h2000);
        deliver_notice();

        // Largest 15-bit limits, voltage checks off; the all-ones write must lose its top bit.
        drain_results();
        set_register(CFG_OVER_CURRENT_LIMIT, 16'hFFFF);
        set_register(CFG_OVER_TEMPERATURE_LIMIT, 16'h7FFF);
        set_register(CFG_OVER_VOLTAGE_LIMIT, 16'h0000);
        set_register(CFG_UNDER_VOLTAGE_LIMIT, 16'h0000);
        send_item(OP_EVALUATE, 16'h7FFF, 16'h8001, 16'h7FFF, 16'hFFFF, 16'h7FFF);
        send_item(OP_EVALUATE, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);

        // Disarming clears the episode; a write to an unused index does nothing.
        drain_results();
        set_register(CFG_ARMED, 16'h0000);
        deliver_notice();
        send_item(OP_EVALUATE, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h7FFF);
        drain_results();
        set_register(CfgUnusedIndex, 16'hFFFF);
        set_register(CFG_ARMED, 16'hFFFF);
        send_item(OP_EVALUATE, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
        deliver_notice();

        // Random phases, each under a fresh configuration.
        issued = 0;
        phase = 0;
        while (issued < RandomItems) begin
            drain_results();
            burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
                set_register(CFG_OVER_CURRENT_LIMIT, pick_setting(64, 4000));
            end
            if ($urandom_range(0, 9) < 7) begin
                set_register(CFG_OVER_VOLTAGE_LIMIT, pick_setting(16'h8000, 16'hF000));
            end
            if ($urandom_range(0, 9) < 7) begin
                set_register(CFG_UNDER_VOLTAGE_LIMIT, pick_setting(16'h1000, 16'h7000));
            end
            if ($urandom_range(0, 9) < 7) begin
                set_register(CFG_OVER_TEMPERATURE_LIMIT, pick_setting(16'h1000, 16'h6000));
            end
            if ($urandom_range(0, 9) == 0) begin
                set_register(CfgUnusedIndex, 16'($urandom));
            end
            set_register(CFG_ARMED,
                         16'(($urandom & 16'hFFFE) | 16'($urandom_range(0, 7) != 0)));
            phase_items = $urandom_range(20, 70);
            // One phase keeps items coming while the result side holds off.
            if (phase == 3) begin
                hold_request = 1'b1;
                burst_mode = 1'b1;
                phase_items = 60;
            end
            repeat (phase_items) begin
                op = ($urandom_range(0, 99) < 30) ? OP_DELIVER : OP_EVALUATE;
                cur_mode = $urandom_range(0, 4) / 2;
                volt_mode = $urandom_range(0, 4) / 2;
                temp_mode = $urandom_range(0, 4) / 2;
                send_item(op, pick_current(cur_mode), pick_current(cur_mode),
                          pick_current(cur_mode), pick_voltage(volt_mode),
                          pick_temperature(temp_mode));
            end
            hold_request = 1'b0;
            issued += phase_items;
            phase++;
        end

        drain_results();
        burst_mode = 1'b0;
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && results_awaited == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fdm_pkg.sv
src/fdm_current_lane.sv
src/fdm_fault_merge.sv
src/motor_drive_fault_monitor_top.sv
bench/fault_monitor_checker.sv
bench/tb.sv
